// ===== hdl/lsm_pkg.sv =====
`timescale 1ns / 1ps

package lsm_pkg;

  localparam int MAX_ITEMS = 256;
  localparam int ID_W      = 9;
  localparam int ADDR_W    = 8;
  localparam int ST_W      = 2;

  localparam logic             OP_INSERT  = 1'b0;
  localparam logic             OP_REMOVE  = 1'b1;
  localparam logic [ST_W-1:0]  ST_OK      = 2'd0;
  localparam logic [ST_W-1:0]  ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0]  ST_BAD_REF = 2'd2;

  typedef struct packed {
    logic            opcode;
    logic [ID_W-1:0] ref_id;
  } request_t;

  typedef struct packed {
    logic [ID_W-1:0] result_id;
    logic [ST_W-1:0] status;
    logic [ID_W-1:0] item_count;
    logic [ID_W-1:0] head_id;
    logic [ID_W-1:0] tail_id;
  } result_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic link;
  } ctl_cmd_t;

  typedef struct packed {
    logic err;
    logic insert;
  } ctl_stat_t;

  function automatic logic [ADDR_W-1:0] id_addr(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] tmp;
    tmp = id - ID_W'(1);
    return tmp[ADDR_W-1:0];
  endfunction

endpackage

// ===== hdl/lsm_ctrl.sv =====
`timescale 1ns / 1ps

module lsm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  lsm_pkg::ctl_stat_t stat,
  output lsm_pkg::ctl_cmd_t  cmd,
  output logic               busy,
  output logic               done
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LINK = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       done_next;

  always_comb begin
    cmd.capture = (state == S_IDLE) && start;
    cmd.exec    = (state == S_EXEC);
    cmd.link    = (state == S_LINK);
    busy        = (state != S_IDLE);
    state_next  = state;
    done_next   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.err || !stat.insert) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end else begin
          state_next = S_LINK;
        end
      end
      S_LINK: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // a result only follows the last step of a request
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_EXEC || $past(state) == S_LINK))
    else $error("result strobe without a request in flight");

endmodule

// ===== hdl/lsm_datapath.sv =====
`timescale 1ns / 1ps

module lsm_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  lsm_pkg::ctl_cmd_t        cmd,
  input  lsm_pkg::request_t        request,
  output lsm_pkg::ctl_stat_t       stat,
  output lsm_pkg::result_t         response
);

  localparam int ID_W   = lsm_pkg::ID_W;
  localparam int ADDR_W = lsm_pkg::ADDR_W;
  localparam int DEPTH  = lsm_pkg::MAX_ITEMS;

  logic [ID_W-1:0] next_mem  [DEPTH];
  logic [ID_W-1:0] prev_mem  [DEPTH];
  logic [ID_W-1:0] stack_mem [DEPTH];

  logic [ID_W-1:0] nxt_q, prv_q, stk_q;
  logic            op_q;
  logic [ID_W-1:0] ref_q;
  logic [ID_W-1:0] id_r, succ_r;

  logic [ID_W-1:0]  count, count_next;
  logic [ID_W-1:0]  hw, hw_next;
  logic [ID_W-1:0]  head, head_next;
  logic [ID_W-1:0]  tail, tail_next;
  logic [DEPTH-1:0] in_use, in_use_next;

  logic                    ref_ok, is_full, insert;
  logic [lsm_pkg::ST_W-1:0] code;
  logic [ID_W-1:0]         new_id, succ, res_id;
  logic [ADDR_W-1:0]       ref_a;

  logic              next_we, prev_we, stack_we;
  logic [ADDR_W-1:0] next_wa, prev_wa, stack_wa;
  logic [ID_W-1:0]   next_wd, prev_wd;

  always_comb begin
    ref_a   = lsm_pkg::id_addr(ref_q);
    insert  = (op_q == lsm_pkg::OP_INSERT);
    ref_ok  = (ref_q != '0) && (ref_q <= ID_W'(DEPTH)) && in_use[ref_a];
    is_full = (count == ID_W'(DEPTH));
    if (insert) begin
      if (is_full)                    code = lsm_pkg::ST_FULL;
      else if (ref_q != '0 && !ref_ok) code = lsm_pkg::ST_BAD_REF;
      else                            code = lsm_pkg::ST_OK;
    end else begin
      code = (!ref_ok || count == '0) ? lsm_pkg::ST_BAD_REF : lsm_pkg::ST_OK;
    end
    // slots below the high-water mark were refilled by removes
    new_id = (count < hw) ? stk_q : count + ID_W'(1);
    succ   = (ref_q == '0) ? head : nxt_q;

    count_next  = count;
    hw_next     = hw;
    head_next   = head;
    tail_next   = tail;
    in_use_next = in_use;
    next_we  = 1'b0;
    prev_we  = 1'b0;
    stack_we = 1'b0;
    next_wa  = '0;
    prev_wa  = '0;
    stack_wa = lsm_pkg::id_addr(count);
    next_wd  = '0;
    prev_wd  = '0;
    res_id   = '0;

    if (cmd.exec && code == lsm_pkg::ST_OK) begin
      if (insert) begin
        next_we = 1'b1;
        next_wa = lsm_pkg::id_addr(new_id);
        next_wd = succ;
        prev_we = 1'b1;
        prev_wa = lsm_pkg::id_addr(new_id);
        prev_wd = ref_q;
        if (ref_q == '0) head_next = new_id;
        if (succ == '0)  tail_next = new_id;
        in_use_next[lsm_pkg::id_addr(new_id)] = 1'b1;
        count_next = count + ID_W'(1);
        if (count == hw) hw_next = hw + ID_W'(1);
        res_id = new_id;
      end else begin
        if (nxt_q != '0) begin
          prev_we = 1'b1;
          prev_wa = lsm_pkg::id_addr(nxt_q);
          prev_wd = prv_q;
        end else begin
          tail_next = prv_q;
        end
        if (prv_q != '0) begin
          next_we = 1'b1;
          next_wa = lsm_pkg::id_addr(prv_q);
          next_wd = nxt_q;
        end else begin
          head_next = nxt_q;
        end
        in_use_next[ref_a] = 1'b0;
        stack_we   = 1'b1;
        count_next = count - ID_W'(1);
        res_id     = prv_q;
      end
    end

    // second half of an insert: patch the neighbors
    if (cmd.link) begin
      if (ref_q != '0) begin
        next_we = 1'b1;
        next_wa = ref_a;
        next_wd = id_r;
      end
      if (succ_r != '0) begin
        prev_we = 1'b1;
        prev_wa = lsm_pkg::id_addr(succ_r);
        prev_wd = id_r;
      end
    end

    stat.err    = (code != lsm_pkg::ST_OK);
    stat.insert = insert;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      nxt_q <= next_mem[lsm_pkg::id_addr(request.ref_id)];
      prv_q <= prev_mem[lsm_pkg::id_addr(request.ref_id)];
      stk_q <= stack_mem[count[ADDR_W-1:0]];
      op_q  <= request.opcode;
      ref_q <= request.ref_id;
    end
    if (next_we)  next_mem[next_wa]   <= next_wd;
    if (prev_we)  prev_mem[prev_wa]   <= prev_wd;
    if (stack_we) stack_mem[stack_wa] <= ref_q;
    if (cmd.exec) begin
      id_r   <= new_id;
      succ_r <= succ;
      response.result_id  <= res_id;
      response.status     <= code;
      response.item_count <= count_next;
      response.head_id    <= head_next;
      response.tail_id    <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      hw     <= '0;
      head   <= '0;
      tail   <= '0;
      in_use <= '0;
    end else begin
      count  <= count_next;
      hw     <= hw_next;
      head   <= head_next;
      tail   <= tail_next;
      in_use <= in_use_next;
    end
  end

  a_count_hw: assert property (@(posedge clk) disable iff (rst)
    count <= hw && hw <= ID_W'(DEPTH))
    else $error("item count above high-water mark");

  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (count == '0) == (head == '0) && (count == '0) == (tail == '0))
    else $error("head or tail disagrees with item count");

  a_in_use_count: assert property (@(posedge clk) disable iff (rst)
    $countones(in_use) == int'(count))
    else $error("in-use bits disagree with item count");

endmodule

// ===== hdl/linked_list_slot_manager_top.sv =====
`timescale 1ns / 1ps

// channel   | ports                         | handshake
// request   | start, busy, request          | taken when start high and busy low
// response  | done, response                | valid for the one cycle done is high
//
// a remove or a failed request passes through EXEC and back to IDLE before the next acceptance;
// a successful insert also passes through LINK: the single write port of each link memory needs a
// separate step to patch the neighbors of the new id
// done rises the cycle after the last step, busy is already low then
// reset clears count, head, tail and in-use bits; link memories are not cleared
// the receiver cannot stall; each response is shown for exactly one cycle
module linked_list_slot_manager_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lsm_pkg::request_t request,
  output logic              busy,
  output logic              done,
  output lsm_pkg::result_t  response
);

  lsm_pkg::ctl_cmd_t  cmd;
  lsm_pkg::ctl_stat_t stat;

  lsm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  lsm_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .request  (request),
    .stat     (stat),
    .response (response)
  );

endmodule

// ===== sim/tb_linked_list_slot_manager_top.sv =====
`timescale 1ns / 1ps

module tb_linked_list_slot_manager_top;

  localparam int IDLE_LIMIT = 2000;
  localparam int ID_W       = lsm_pkg::ID_W;
  localparam int MAX_ITEMS  = lsm_pkg::MAX_ITEMS;

  class slot_list_tracker;
    logic [ID_W-1:0]  next_id [0:MAX_ITEMS];
    logic [ID_W-1:0]  prev_id [0:MAX_ITEMS];
    logic [ID_W-1:0]  free_ids [0:MAX_ITEMS-1];
    bit               live [0:MAX_ITEMS];
    int               count;
    logic [ID_W-1:0]  head;
    logic [ID_W-1:0]  tail;
    lsm_pkg::result_t expected_results [$];
    int               errors;

    function new();
      for (int i = 0; i <= MAX_ITEMS; i++) begin
        next_id[i] = '0;
        prev_id[i] = '0;
        live[i]    = 1'b0;
      end
      // lowest id pops first
      for (int i = 0; i < MAX_ITEMS; i++) free_ids[MAX_ITEMS-1-i] = ID_W'(i + 1);
      count  = 0;
      head   = '0;
      tail   = '0;
      errors = 0;
    endfunction

    function bit is_live(logic [ID_W-1:0] id);
      return id != 0 && id <= MAX_ITEMS && live[id];
    endfunction

    function lsm_pkg::result_t apply_request(lsm_pkg::request_t req);
      lsm_pkg::result_t res;
      logic [ID_W-1:0]  anchor;
      logic [ID_W-1:0]  id;
      logic [ID_W-1:0]  succ;
      logic [ID_W-1:0]  nx;
      logic [ID_W-1:0]  pv;
      res    = '0;
      anchor = req.ref_id;
      if (req.opcode == lsm_pkg::OP_INSERT) begin
        if (count >= MAX_ITEMS) begin
          res.status = lsm_pkg::ST_FULL;
        end else if (anchor != 0 && !is_live(anchor)) begin
          res.status = lsm_pkg::ST_BAD_REF;
        end else begin
          id          = free_ids[MAX_ITEMS-1-count];
          succ        = (anchor == 0) ? head : next_id[anchor];
          next_id[id] = succ;
          prev_id[id] = anchor;
          if (anchor != 0) next_id[anchor] = id;
          else head = id;
          if (succ != 0) prev_id[succ] = id;
          else tail = id;
          live[id]      = 1'b1;
          count++;
          res.status    = lsm_pkg::ST_OK;
          res.result_id = id;
        end
      end else begin
        if (!is_live(anchor) || count == 0) begin
          res.status = lsm_pkg::ST_BAD_REF;
        end else begin
          nx = next_id[anchor];
          pv = prev_id[anchor];
          if (nx != 0) prev_id[nx] = pv;
          else tail = pv;
          if (pv != 0) next_id[pv] = nx;
          else head = nx;
          live[anchor]               = 1'b0;
          free_ids[MAX_ITEMS-count] = anchor;
          count--;
          res.status    = lsm_pkg::ST_OK;
          res.result_id = pv;
        end
      end
      res.item_count = ID_W'(count);
      res.head_id    = head;
      res.tail_id    = tail;
      return res;
    endfunction

    function void note_request(lsm_pkg::request_t req);
      expected_results.push_back(apply_request(req));
    endfunction

    function void check_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_response(lsm_pkg::result_t got);
      lsm_pkg::result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected response: expected none, got %h", $time, got);
        return;
      end
      want = expected_results.pop_front();
      check_field("result_id", want.result_id, got.result_id);
      check_field("status", ID_W'(want.status), ID_W'(got.status));
      check_field("item_count", want.item_count, got.item_count);
      check_field("head_id", want.head_id, got.head_id);
      check_field("tail_id", want.tail_id, got.tail_id);
    endfunction

    function logic [ID_W-1:0] pick_live();
      logic [ID_W-1:0] id;
      int              steps;
      if (count == 0) return '0;
      repeat (32) begin
        id = ID_W'($urandom_range(1, MAX_ITEMS));
        if (live[id]) return id;
      end
      id    = head;
      steps = $urandom_range(0, count - 1);
      repeat (steps) id = next_id[id];
      return id;
    endfunction
  endclass

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              start   = 1'b0;
  lsm_pkg::request_t request = '0;
  logic              busy;
  logic              done;
  lsm_pkg::result_t  response;
  int                idle_cycles = 0;

  slot_list_tracker tracker = new();

  linked_list_slot_manager_top uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .request  (request),
    .busy     (busy),
    .done     (done),
    .response (response)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) tracker.check_response(response);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic pause_random();
    int roll;
    int gap;
    roll = $urandom_range(0, 99);
    if (roll < 50) gap = 0;
    else if (roll < 85) gap = $urandom_range(1, 3);
    else if (roll < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic issue(logic op, logic [ID_W-1:0] id);
    lsm_pkg::request_t req;
    req.opcode = op;
    req.ref_id = id;
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    tracker.note_request(req);
    pause_random();
  endtask

  task automatic random_item(int insert_pct);
    logic            op;
    logic [ID_W-1:0] id;
    if ($urandom_range(0, 99) < 8) begin
      // noise
      op = 1'($urandom_range(0, 1));
      id = ID_W'($urandom_range(0, 511));
    end else begin
      op = ($urandom_range(0, 99) < insert_pct) ? lsm_pkg::OP_INSERT : lsm_pkg::OP_REMOVE;
      if (op == lsm_pkg::OP_INSERT && $urandom_range(0, 5) == 0) id = '0;
      else if ($urandom_range(0, 7) == 0) id = tracker.tail;
      else id = tracker.pick_live();
    end
    issue(op, id);
  endtask

  task automatic wait_drained();
    while (tracker.expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // bad references on an empty list
    issue(lsm_pkg::OP_REMOVE, 9'd0);
    issue(lsm_pkg::OP_REMOVE, 9'd256);
    issue(lsm_pkg::OP_INSERT, 9'd5);
    issue(lsm_pkg::OP_INSERT, 9'd511);
    issue(lsm_pkg::OP_INSERT, 9'd256);
    // single item is both head and tail
    issue(lsm_pkg::OP_INSERT, 9'd0);
    issue(lsm_pkg::OP_REMOVE, 9'd1);
    // head, tail and middle inserts
    issue(lsm_pkg::OP_INSERT, 9'd0);
    issue(lsm_pkg::OP_INSERT, 9'd1);
    issue(lsm_pkg::OP_INSERT, 9'd0);
    issue(lsm_pkg::OP_INSERT, 9'd1);
    // middle, head, tail removes, then a repeat remove of a freed id
    issue(lsm_pkg::OP_REMOVE, 9'd1);
    issue(lsm_pkg::OP_REMOVE, 9'd3);
    issue(lsm_pkg::OP_REMOVE, 9'd2);
    issue(lsm_pkg::OP_REMOVE, 9'd2);
    // freed id comes back first
    issue(lsm_pkg::OP_INSERT, 9'd0);
    issue(lsm_pkg::OP_INSERT, 9'd4);
    issue(lsm_pkg::OP_REMOVE, 9'd4);
    issue(lsm_pkg::OP_REMOVE, 9'd2);
    issue(lsm_pkg::OP_REMOVE, 9'd1);

    repeat (600) random_item(50);

    // fill up, then inserts while full, including a bad reference, then a remove and a tail insert
    while (tracker.count < MAX_ITEMS) random_item(90);
    repeat (12) issue(lsm_pkg::OP_INSERT, tracker.pick_live());
    issue(lsm_pkg::OP_INSERT, 9'd300);
    issue(lsm_pkg::OP_INSERT, 9'd0);
    issue(lsm_pkg::OP_REMOVE, 9'd256);
    issue(lsm_pkg::OP_INSERT, tracker.tail);

    start <= 1'b0;
    wait_drained();

    while (tracker.count > 0) random_item(10);
    repeat (500) random_item(60);

    start <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
